@@ hw/rtl/mts_pkg.sv @@
package mts_pkg;

    // default stack depth
    localparam int unsigned DEPTH_DEFAULT = 1024;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 11;

    // minimum reported for an empty stack
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

@@ hw/rtl/mts_ram.sv @@
module mts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hw/rtl/min_tracking_stack.sv @@
// min tracking stack: push, pop and minimum query on signed 32-bit values
// the result strobe o_valid is registered and rises in the cycle after the command transfer
// commands are taken back to back, except that a pop that removes a value holds busy high
//   while the new top entries come back from the value and minimum RAMs
// the receiver cannot stall, each result stands for exactly one cycle
// reset (synchronous, active low) empties both stacks; RAM contents are kept
module min_tracking_stack #(
    parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mts_pkg::CMD_W-1:0]         i_command,
    input  logic signed [mts_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_valid,
    output logic signed [mts_pkg::DATA_W-1:0] o_result_value,
    output logic [mts_pkg::STAT_W-1:0]        o_status,
    output logic [mts_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state r_state;

    // counts of the value stack and the minima stack
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_min_count;

    // cached top entries, the RAMs hold every entry including the top
    logic signed [mts_pkg::DATA_W-1:0] r_top_val;
    logic signed [mts_pkg::DATA_W-1:0] r_top_min;

    // set when the pending pop also dropped a minimum
    logic r_min_pop;

    logic                      accept;
    logic                      is_push;
    logic                      is_pop;
    logic                      is_query;
    logic                      full;
    logic                      empty;
    logic                      min_empty;
    logic                      new_min;
    logic                      top_is_min;

    logic                      val_we;
    logic                      min_we;
    logic                      rd_en;
    logic [AW-1:0]             val_waddr;
    logic [AW-1:0]             min_waddr;
    logic [AW-1:0]             val_raddr;
    logic [AW-1:0]             min_raddr;
    logic [mts_pkg::DATA_W-1:0] val_rdata;
    logic [mts_pkg::DATA_W-1:0] min_rdata;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign is_push   = (i_command == mts_pkg::CMD_PUSH);
    assign is_pop    = (i_command == mts_pkg::CMD_POP);
    assign is_query  = (i_command == mts_pkg::CMD_QUERY);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign min_empty = (r_min_count == '0);

    // an empty minima stack stands for INT_MAX, which every value meets
    assign new_min    = min_empty || (i_push_value <= r_top_min);
    assign top_is_min = !min_empty && (r_top_val == r_top_min);

    // push writes the new top straight into the value RAM, and into the minimum RAM for a new minimum
    assign val_we    = accept && is_push && !full;
    assign min_we    = val_we && new_min && (r_min_count < CW'(DEPTH));
    assign val_waddr = r_count[AW-1:0];
    assign min_waddr = r_min_count[AW-1:0];

    // pop fetches the entries just below the tops; a read below entry zero only
    // happens when that stack empties or keeps its top, and the data is then never used
    assign rd_en     = accept && is_pop && !empty;
    assign val_raddr = AW'(r_count - CW'(2));
    assign min_raddr = AW'(r_min_count - CW'(2));

    mts_ram #(
        .WIDTH (mts_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (i_push_value),
        .i_re    (rd_en),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    mts_ram #(
        .WIDTH (mts_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (min_waddr),
        .i_wdata (i_push_value),
        .i_re    (rd_en),
        .i_raddr (min_raddr),
        .o_rdata (min_rdata)
    );

    assign o_occupancy = mts_pkg::OCC_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_min_count    <= '0;
            r_min_pop      <= 1'b0;
            o_valid        <= 1'b0;
            o_result_value <= '0;
            o_status       <= mts_pkg::STAT_OK;
        end else begin
            o_valid <= accept;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        o_result_value <= '0;
                        o_status       <= mts_pkg::STAT_OK;
                        if (is_push) begin
                            if (full) begin
                                o_status <= mts_pkg::STAT_FULL;
                            end else begin
                                r_count   <= r_count + CW'(1);
                                r_top_val <= i_push_value;
                                if (new_min && (r_min_count < CW'(DEPTH))) begin
                                    r_min_count <= r_min_count + CW'(1);
                                    r_top_min   <= i_push_value;
                                end
                            end
                        end else if (is_pop) begin
                            if (empty) begin
                                o_status <= mts_pkg::STAT_EMPTY;
                            end else begin
                                o_result_value <= r_top_val;
                                r_count        <= r_count - CW'(1);
                                r_min_pop      <= top_is_min;
                                if (top_is_min) begin
                                    r_min_count <= r_min_count - CW'(1);
                                end
                                r_state <= S_LOAD;
                            end
                        end else if (is_query) begin
                            o_result_value <= min_empty ? mts_pkg::INT_MAX : r_top_min;
                        end
                    end
                end
                S_LOAD: begin
                    // refill the cached tops from the RAM read issued at the pop
                    r_top_val <= val_rdata;
                    if (r_min_pop) begin
                        r_top_min <= min_rdata;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // every running minimum belongs to a held value
    a_min_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_count <= r_count)
        else $error("minima stack deeper than value stack");

    // the refill stall follows only an accepted pop, and the state after it is always idle
    a_load_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(accept) && $past(is_pop) && o_valid))
        else $error("refill without a pop transfer");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_IDLE))
        else $error("refill longer than one cycle");

    // a refused push leaves the stack full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mts_pkg::STAT_FULL)) |-> (r_count == CW'(DEPTH)))
        else $error("push refused while not full");
`endif

endmodule

@@ tb/min_tracking_stack_test.sv @@
`timescale 1ns / 100ps

module min_tracking_stack_test;

    localparam int unsigned STACK_DEPTH = mts_pkg::DEPTH_DEFAULT;

    // code 3 is not a command: the block answers with a no-op result
    localparam logic [mts_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [mts_pkg::DATA_W-1:0] value;
        logic [mts_pkg::STAT_W-1:0]        status;
        logic [mts_pkg::OCC_W-1:0]         occupancy;
    } t_stack_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [mts_pkg::CMD_W-1:0]         i_command = mts_pkg::CMD_QUERY;
    logic signed [mts_pkg::DATA_W-1:0] i_push_value = '0;
    logic                              o_valid;
    logic signed [mts_pkg::DATA_W-1:0] o_result_value;
    logic [mts_pkg::STAT_W-1:0]        o_status;
    logic [mts_pkg::OCC_W-1:0]         o_occupancy;

    // shadow of the stack contents, updated at each command transfer
    logic signed [mts_pkg::DATA_W-1:0] value_mem [STACK_DEPTH];
    logic signed [mts_pkg::DATA_W-1:0] min_mem [STACK_DEPTH];
    int unsigned                       value_cnt = 0;
    int unsigned                       min_cnt = 0;

    // results still owed by the block, oldest first
    t_stack_result                     pending_results [$];
    t_stack_result                     want;
    int unsigned                       error_count = 0;
    bit                                idle_enable = 1'b1;

    min_tracking_stack #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs on busy or never answers
    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // running minimum, INT_MAX for an empty stack
    function automatic logic signed [mts_pkg::DATA_W-1:0] min_now();
        if (min_cnt == 0) begin
            return mts_pkg::INT_MAX;
        end
        return min_mem[min_cnt - 1];
    endfunction

    // apply one command to the shadow stack and return what the block must answer
    function automatic t_stack_result apply_command(
        input logic [mts_pkg::CMD_W-1:0]         cmd,
        input logic signed [mts_pkg::DATA_W-1:0] val
    );
        t_stack_result                     res;
        logic signed [mts_pkg::DATA_W-1:0] top;
        res.value  = '0;
        res.status = mts_pkg::STAT_OK;
        case (cmd)
            mts_pkg::CMD_PUSH: begin
                if (value_cnt >= STACK_DEPTH) begin
                    res.status = mts_pkg::STAT_FULL;
                end else begin
                    // ties go onto the minima stack too, so duplicates pop cleanly
                    if (val <= min_now() && min_cnt < STACK_DEPTH) begin
                        min_mem[min_cnt] = val;
                        min_cnt++;
                    end
                    value_mem[value_cnt] = val;
                    value_cnt++;
                end
            end
            mts_pkg::CMD_POP: begin
                if (value_cnt == 0) begin
                    res.status = mts_pkg::STAT_EMPTY;
                end else begin
                    top = value_mem[value_cnt - 1];
                    if (min_cnt > 0 && top == min_now()) begin
                        min_cnt--;
                    end
                    value_cnt--;
                    res.value = top;
                end
            end
            mts_pkg::CMD_QUERY: begin
                res.value = min_now();
            end
            default: begin
            end
        endcase
        res.occupancy = mts_pkg::OCC_W'(value_cnt);
        return res;
    endfunction

    // push operands: a mix of full-range values, values near zero, extremes
    // and copies of the current minimum or top to exercise tie handling
    function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
        int unsigned sel;
        int          offset;
        sel    = $urandom_range(0, 99);
        offset = int'($urandom_range(0, 16)) - 8;
        if (sel < 30) begin
            return $urandom;
        end else if (sel < 55) begin
            return offset;
        end else if (sel < 72) begin
            return (min_cnt != 0) ? min_now() : mts_pkg::DATA_W'(offset);
        end else if (sel < 82) begin
            return min_now() + offset;
        end else if (sel < 92) begin
            case ($urandom_range(0, 3))
                0: return mts_pkg::INT_MAX;
                1: return ~mts_pkg::INT_MAX;
                2: return -1;
                default: return 0;
            endcase
        end else if (value_cnt != 0) begin
            return value_mem[value_cnt - 1];
        end
        return $urandom;
    endfunction

    // one command transfer; start is left high so commands can follow back to back,
    // and only lowered for an idle gap or a drain
    task automatic send_cmd(input logic [mts_pkg::CMD_W-1:0] cmd,
                            input logic signed [mts_pkg::DATA_W-1:0] val);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 2);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_command(cmd, val));
    endtask

    // hold off new commands until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // empty stack corners, ties on the minimum, extreme values, unused code
    task automatic test_directed();
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'shFFFF_FFFF);
        send_cmd(CMD_UNUSED, 32'shFFFF_FFFF);
        send_cmd(mts_pkg::CMD_PUSH, 32'sd5);
        send_cmd(mts_pkg::CMD_PUSH, 32'sd5);
        send_cmd(mts_pkg::CMD_PUSH, 32'sd7);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_PUSH, mts_pkg::INT_MAX);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_PUSH, ~mts_pkg::INT_MAX);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_PUSH, -32'sd1);
        send_cmd(mts_pkg::CMD_PUSH, 32'sd0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_POP, 32'sh0);
        send_cmd(mts_pkg::CMD_QUERY, 32'sh0);
    endtask

    // shallow random walk: the stack keeps emptying, so refused pops are common
    task automatic test_shallow_mix(input int unsigned count);
        int unsigned               sel;
        logic [mts_pkg::CMD_W-1:0] cmd;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < ((value_cnt > 12) ? 25 : 42)) begin
                cmd = mts_pkg::CMD_PUSH;
            end else if (sel < 82) begin
                cmd = mts_pkg::CMD_POP;
            end else if (sel < 96) begin
                cmd = mts_pkg::CMD_QUERY;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_cmd(cmd, pick_value());
        end
    endtask

    // climb to full depth, then work around the full boundary
    task automatic test_fill_to_full();
        int unsigned               sel;
        int unsigned               sent;
        logic [mts_pkg::CMD_W-1:0] cmd;
        sent = 0;
        // first stretch runs back to back with no gaps at all
        idle_enable = 1'b0;
        while (value_cnt < STACK_DEPTH) begin
            if (sent == 400) begin
                idle_enable = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 88) begin
                cmd = mts_pkg::CMD_PUSH;
            end else if (sel < 94) begin
                cmd = mts_pkg::CMD_POP;
            end else if (sel < 98) begin
                cmd = mts_pkg::CMD_QUERY;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_cmd(cmd, pick_value());
            sent++;
        end
        idle_enable = 1'b1;
        repeat (20) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                cmd = mts_pkg::CMD_PUSH;
            end else if (sel < 78) begin
                cmd = mts_pkg::CMD_POP;
            end else begin
                cmd = mts_pkg::CMD_QUERY;
            end
            send_cmd(cmd, pick_value());
        end
    endtask

    // result checker: the block cannot be held off, so every strobe is a transfer
    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value %0d status %0d occupancy %0d",
                         $time, o_result_value, o_status, o_occupancy);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.value) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.value, o_result_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, o_occupancy);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        // full drain before moving on, the sender sits idle meanwhile
        wait_drained();
        test_shallow_mix(300);
        wait_drained();
        test_fill_to_full();
        wait_drained();

        // keep the clock running so a stray extra strobe would still be caught
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
